/* rtl/fbc_pkg.sv */
// ----------------------------------------------------------------------------
// fbc_pkg
// Shared types, field layout and codes of the frustum box cull block.
// ----------------------------------------------------------------------------
package fbc_pkg;

    localparam int NUM_PLANES_DEF = 6;

    localparam int IDX_W    = 3;
    localparam int NORM_W   = 18;
    localparam int COORD_W  = 32;
    localparam int PROD_W   = NORM_W + COORD_W;     // one normal times one coordinate
    localparam int FRAC_W   = 16;
    localparam int DSH_W    = COORD_W + FRAC_W;     // offset scaled to the product format
    localparam int PSUM_W   = PROD_W + 1;
    localparam int DIST_W   = PROD_W + 2;

    localparam int S_DATA_W = 288;
    localparam int M_DATA_W = 8;

    // s_axis_tdata layout
    localparam int IDX_LSB  = 0;
    localparam int A_LSB    = IDX_LSB + IDX_W;
    localparam int B_LSB    = A_LSB + NORM_W;
    localparam int C_LSB    = B_LSB + NORM_W;
    localparam int D_LSB    = C_LSB + NORM_W;
    localparam int MINX_LSB = D_LSB + COORD_W;
    localparam int MINY_LSB = MINX_LSB + COORD_W;
    localparam int MINZ_LSB = MINY_LSB + COORD_W;
    localparam int MAXX_LSB = MINZ_LSB + COORD_W;
    localparam int MAXY_LSB = MAXX_LSB + COORD_W;
    localparam int MAXZ_LSB = MAXY_LSB + COORD_W;

    typedef enum logic {
        CMD_LOAD = 1'b0,
        CMD_TEST = 1'b1
    } t_cmd;

    typedef struct packed {
        logic signed [NORM_W-1:0]  a;
        logic signed [NORM_W-1:0]  b;
        logic signed [NORM_W-1:0]  c;
        logic signed [COORD_W-1:0] d;
    } t_plane;

    typedef struct packed {
        logic signed [COORD_W-1:0] lo_x;
        logic signed [COORD_W-1:0] lo_y;
        logic signed [COORD_W-1:0] lo_z;
        logic signed [COORD_W-1:0] hi_x;
        logic signed [COORD_W-1:0] hi_y;
        logic signed [COORD_W-1:0] hi_z;
    } t_box;

    typedef struct packed {
        logic             we;
        logic [IDX_W-1:0] idx;
    } t_load;

endpackage

/* rtl/frustum_box_cull.sv */
// ----------------------------------------------------------------------------
// frustum_box_cull
// Six-plane frustum test of axis-aligned boxes, fixed point, exact sums.
// ----------------------------------------------------------------------------
//  channel   dir  handshake                  payload
//  s_axis    in   s_axis_tvalid/tready       tuser: command; tdata: plane and box
//  m_axis    out  m_axis_tvalid/tready       tdata: visible
//
//  While no result waits on m_axis, one transaction a cycle enters; a test
//  result passes the input register, products, partial sums and output
//  register before it is offered on m_axis.
//  A load writes its plane at the accepting edge and gives no result.
//  Reset clears the valid bits only and holds s_axis_tready low; planes hold
//  garbage until loaded.
//  While a result waits on m_axis the whole pipeline holds and s_axis_tready
//  falls; nothing is lost or repeated.
// ----------------------------------------------------------------------------
module frustum_box_cull #(
    parameter int NUM_PLANES = fbc_pkg::NUM_PLANES_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // [2:0] plane_index, [20:3] plane_a, [38:21] plane_b, [56:39] plane_c,
    // [88:57] plane_d, [120:89] min_x, [152:121] min_y, [184:153] min_z,
    // [216:185] max_x, [248:217] max_y, [280:249] max_z, [287:281] zero
    input  logic [fbc_pkg::S_DATA_W-1:0]  s_axis_tdata,
    // [0] command
    input  logic                          s_axis_tuser,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // [0] visible, [7:1] zero
    output logic [fbc_pkg::M_DATA_W-1:0]  m_axis_tdata
);

    localparam int CW = fbc_pkg::COORD_W;
    localparam int NW = fbc_pkg::NORM_W;

    logic            en;
    logic            accept;
    fbc_pkg::t_load  load;
    fbc_pkg::t_plane in_plane;
    fbc_pkg::t_box   in_box;
    fbc_pkg::t_plane planes [NUM_PLANES];
    fbc_pkg::t_box   r_box;
    logic            r_v1, r_v2, r_v3, r_vo;
    logic            r_vis;
    logic [NUM_PLANES-1:0] cull;

    assign en            = !(r_vo && !m_axis_tready);
    // take nothing while in reset
    assign s_axis_tready = en && i_rst_n;
    assign accept        = s_axis_tvalid && s_axis_tready;

    assign load.we  = accept && (s_axis_tuser == fbc_pkg::CMD_LOAD);
    assign load.idx = s_axis_tdata[fbc_pkg::IDX_LSB +: fbc_pkg::IDX_W];

    assign in_plane.a = s_axis_tdata[fbc_pkg::A_LSB +: NW];
    assign in_plane.b = s_axis_tdata[fbc_pkg::B_LSB +: NW];
    assign in_plane.c = s_axis_tdata[fbc_pkg::C_LSB +: NW];
    assign in_plane.d = s_axis_tdata[fbc_pkg::D_LSB +: CW];

    assign in_box.lo_x = s_axis_tdata[fbc_pkg::MINX_LSB +: CW];
    assign in_box.lo_y = s_axis_tdata[fbc_pkg::MINY_LSB +: CW];
    assign in_box.lo_z = s_axis_tdata[fbc_pkg::MINZ_LSB +: CW];
    assign in_box.hi_x = s_axis_tdata[fbc_pkg::MAXX_LSB +: CW];
    assign in_box.hi_y = s_axis_tdata[fbc_pkg::MAXY_LSB +: CW];
    assign in_box.hi_z = s_axis_tdata[fbc_pkg::MAXZ_LSB +: CW];

    fbc_plane_store #(
        .NUM_PLANES (NUM_PLANES)
    ) u_store (
        .i_clk    (i_clk),
        .i_load   (load),
        .i_plane  (in_plane),
        .o_planes (planes)
    );

    // a test in the input register reads the planes before any later load lands
    for (genvar g = 0; g < NUM_PLANES; g++) begin : g_lane
        fbc_plane_lane u_lane (
            .i_clk   (i_clk),
            .i_en    (en),
            .i_plane (planes[g]),
            .i_box   (r_box),
            .o_cull  (cull[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_vo <= 1'b0;
        end else if (en) begin
            r_v1 <= accept && (s_axis_tuser == fbc_pkg::CMD_TEST);
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_vo <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_box <= in_box;
            r_vis <= ~|cull;
        end
    end

    assign m_axis_tvalid = r_vo;
    assign m_axis_tdata  = {(fbc_pkg::M_DATA_W-1)'(0), r_vis};

endmodule

/* rtl/fbc_plane_store.sv */
// ----------------------------------------------------------------------------
// fbc_plane_store
// Plane registers, one row per plane, written by load transactions.
// ----------------------------------------------------------------------------
module fbc_plane_store #(
    parameter int NUM_PLANES = fbc_pkg::NUM_PLANES_DEF
) (
    input  logic            i_clk,
    input  fbc_pkg::t_load  i_load,
    input  fbc_pkg::t_plane i_plane,
    output fbc_pkg::t_plane o_planes [NUM_PLANES]
);

    fbc_pkg::t_plane r_planes [NUM_PLANES];

    // an index beyond the last plane matches no row and is dropped
    for (genvar g = 0; g < NUM_PLANES; g++) begin : g_row
        always_ff @(posedge i_clk) begin
            if (i_load.we && (i_load.idx == fbc_pkg::IDX_W'(g))) begin
                r_planes[g] <= i_plane;
            end
        end
        assign o_planes[g] = r_planes[g];
    end

endmodule

/* rtl/fbc_plane_lane.sv */
// ----------------------------------------------------------------------------
// fbc_plane_lane
// One plane test: corner pick and products, partial sums, sign of distance.
// ----------------------------------------------------------------------------
module fbc_plane_lane (
    input  logic            i_clk,
    input  logic            i_en,
    input  fbc_pkg::t_plane i_plane,
    input  fbc_pkg::t_box   i_box,
    output logic            o_cull
);

    localparam int PW = fbc_pkg::PROD_W;
    localparam int SW = fbc_pkg::PSUM_W;
    localparam int DW = fbc_pkg::DIST_W;

    logic signed [fbc_pkg::COORD_W-1:0] sel_x, sel_y, sel_z;
    logic signed [PW-1:0]               n_px, n_py, n_pz;
    logic signed [PW-1:0]               r_px, r_py, r_pz;
    logic signed [fbc_pkg::COORD_W-1:0] r_d;
    logic signed [fbc_pkg::DSH_W-1:0]   d_sh;
    logic signed [SW-1:0]               n_s0, n_s1;
    logic signed [SW-1:0]               r_s0, r_s1;
    logic signed [DW-1:0]               distance;

    // take the corner that lies furthest against the normal
    assign sel_x = i_plane.a[fbc_pkg::NORM_W-1] ? i_box.hi_x : i_box.lo_x;
    assign sel_y = i_plane.b[fbc_pkg::NORM_W-1] ? i_box.hi_y : i_box.lo_y;
    assign sel_z = i_plane.c[fbc_pkg::NORM_W-1] ? i_box.hi_z : i_box.lo_z;

    assign n_px = PW'(i_plane.a) * PW'(sel_x);
    assign n_py = PW'(i_plane.b) * PW'(sel_y);
    assign n_pz = PW'(i_plane.c) * PW'(sel_z);

    assign d_sh = $signed({r_d, fbc_pkg::FRAC_W'(0)});
    assign n_s0 = SW'(r_px) + SW'(r_py);
    assign n_s1 = SW'(r_pz) + SW'(d_sh);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_px <= n_px;
            r_py <= n_py;
            r_pz <= n_pz;
            r_d  <= i_plane.d;
            r_s0 <= n_s0;
            r_s1 <= n_s1;
        end
    end

    assign distance = DW'(r_s0) + DW'(r_s1);
    assign o_cull   = !distance[DW-1] && (|distance);

endmodule

/* rtl/fbc_checker.sv */
// ----------------------------------------------------------------------------
// fbc_checker
// Port-level checks of the frustum box cull block, bound to the top level.
// ----------------------------------------------------------------------------
module fbc_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         s_axis_tready,
    input logic                         m_axis_tvalid,
    input logic                         m_axis_tready,
    input logic [fbc_pkg::M_DATA_W-1:0] m_axis_tdata
);

    // a held result keeps its value until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed or vanished while stalled");

    // reset leaves no result pending
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid straight after reset");

    // input side stalls exactly when a result is blocked
    a_stall_link: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tready == !(m_axis_tvalid && !m_axis_tready))
        else $error("input ready does not follow output stall");

    // only the visible flag is driven in a result
    a_pad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[fbc_pkg::M_DATA_W-1:1] == '0))
        else $error("padding bits of result set");

endmodule

bind frustum_box_cull fbc_checker u_fbc_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

/* verif/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Stream-level check of frustum_box_cull: the plane store and visibility test
// are mirrored in an exact 64-bit predictor. A short table of directed loads
// and tests comes first, then random scenes with random idling on both sides
// and one long output hold-off.
// ----------------------------------------------------------------------------
module tb_top;

    import fbc_pkg::*;

    localparam int NUM_PLANES   = NUM_PLANES_DEF;
    localparam int ITEM_TARGET  = 1450;
    localparam int QUIET_TAIL   = 150;
    localparam int LONG_HOLD    = 300;
    localparam int DRAIN_CYCLES = 16;
    localparam int TIMEOUT      = 1_000_000;

    localparam logic signed [NORM_W-1:0]  N_MIN  = 18'sh20000;
    localparam logic signed [NORM_W-1:0]  N_MAX  = 18'sh1ffff;
    localparam logic signed [NORM_W-1:0]  N_ONE  = 18'sh10000;
    localparam logic signed [NORM_W-1:0]  N_MONE = -18'sh10000;
    localparam logic signed [NORM_W-1:0]  N_ULPN = 18'sh3ffff;
    localparam logic signed [COORD_W-1:0] C_MIN  = 32'sh8000_0000;
    localparam logic signed [COORD_W-1:0] C_MAX  = 32'sh7fff_ffff;
    localparam logic signed [COORD_W-1:0] C_NEG1 = 32'shffff_ffff;

    // plane styles and box styles of a random scene
    localparam int ST_FULL    = 0;
    localparam int ST_FRUSTUM = 1;
    localparam int ST_COARSE  = 2;

    typedef struct {
        t_cmd             cmd;
        logic [IDX_W-1:0] idx;
        t_plane           pl;
        t_box             bx;
        bit               fixed_en;    // visibility typed into the table
        bit               fixed_vis;
    } t_cull_req;

    logic                i_clk   = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                s_valid = 1'b0;
    logic                s_axis_tready;
    logic [S_DATA_W-1:0] s_tdata = '0;
    logic                s_tuser = 1'b0;
    logic                m_axis_tvalid;
    logic                m_ready = 1'b0;
    logic [M_DATA_W-1:0] m_axis_tdata;

    t_plane planes_held [NUM_PLANES];
    bit     vis_expected[$];
    int     err_count    = 0;
    int     items_done   = 0;
    int     tx_gap_pct   = 0;
    int     rx_stall_pct = 0;
    bit     quiet        = 1'b0;
    bit     hold_req     = 1'b0;

    frustum_box_cull DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_valid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_tdata),
        .s_axis_tuser  (s_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_ready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    initial begin
        #(TIMEOUT);
        $display("*** FAILED ***");
        $finish;
    end

    // exact distance of the box corner furthest against each normal
    function automatic bit box_visible(t_box bx);
        longint px, py, pz, distance;
        bit     vis;
        vis = 1'b1;
        for (int i = 0; i < NUM_PLANES; i++) begin
            px   = planes_held[i].a[NORM_W-1] ? longint'(bx.hi_x) : longint'(bx.lo_x);
            py   = planes_held[i].b[NORM_W-1] ? longint'(bx.hi_y) : longint'(bx.lo_y);
            pz   = planes_held[i].c[NORM_W-1] ? longint'(bx.hi_z) : longint'(bx.lo_z);
            distance = longint'(planes_held[i].a) * px + longint'(planes_held[i].b) * py
                     + longint'(planes_held[i].c) * pz
                     + longint'(planes_held[i].d) * 64'sd65536;
            if (distance > 0)
                vis = 1'b0;
        end
        return vis;
    endfunction

    function automatic logic [S_DATA_W-1:0] pack_item(t_cull_req r);
        logic [S_DATA_W-1:0] v;
        v = '0;
        v[IDX_LSB  +: IDX_W]   = r.idx;
        v[A_LSB    +: NORM_W]  = r.pl.a;
        v[B_LSB    +: NORM_W]  = r.pl.b;
        v[C_LSB    +: NORM_W]  = r.pl.c;
        v[D_LSB    +: COORD_W] = r.pl.d;
        v[MINX_LSB +: COORD_W] = r.bx.lo_x;
        v[MINY_LSB +: COORD_W] = r.bx.lo_y;
        v[MINZ_LSB +: COORD_W] = r.bx.lo_z;
        v[MAXX_LSB +: COORD_W] = r.bx.hi_x;
        v[MAXY_LSB +: COORD_W] = r.bx.hi_y;
        v[MAXZ_LSB +: COORD_W] = r.bx.hi_z;
        return v;
    endfunction

    // every field random, so the ignored ones toggle too
    function automatic t_cull_req rand_req(t_cmd cmd);
        t_cull_req r;
        r.cmd       = cmd;
        r.idx       = IDX_W'($urandom);
        r.pl.a      = NORM_W'($urandom);
        r.pl.b      = NORM_W'($urandom);
        r.pl.c      = NORM_W'($urandom);
        r.pl.d      = $urandom;
        r.bx.lo_x   = $urandom;
        r.bx.lo_y   = $urandom;
        r.bx.lo_z   = $urandom;
        r.bx.hi_x   = $urandom;
        r.bx.hi_y   = $urandom;
        r.bx.hi_z   = $urandom;
        r.fixed_en  = 1'b0;
        r.fixed_vis = 1'b0;
        return r;
    endfunction

    function automatic t_cull_req mk_load(logic [IDX_W-1:0] idx,
                                          logic signed [NORM_W-1:0] a,
                                          logic signed [NORM_W-1:0] b,
                                          logic signed [NORM_W-1:0] c,
                                          logic signed [COORD_W-1:0] d);
        t_cull_req r;
        r      = rand_req(CMD_LOAD);
        r.idx  = idx;
        r.pl.a = a;
        r.pl.b = b;
        r.pl.c = c;
        r.pl.d = d;
        return r;
    endfunction

    function automatic t_cull_req mk_test(logic signed [COORD_W-1:0] lx,
                                          logic signed [COORD_W-1:0] ly,
                                          logic signed [COORD_W-1:0] lz,
                                          logic signed [COORD_W-1:0] hx,
                                          logic signed [COORD_W-1:0] hy,
                                          logic signed [COORD_W-1:0] hz,
                                          bit fixed_en, bit fixed_vis);
        t_cull_req r;
        r           = rand_req(CMD_TEST);
        r.bx        = '{lo_x: lx, lo_y: ly, lo_z: lz, hi_x: hx, hi_y: hy, hi_z: hz};
        r.fixed_en  = fixed_en;
        r.fixed_vis = fixed_vis;
        return r;
    endfunction

    // whole units from -8.0 to 8.0, so distances of exactly zero turn up
    function automatic int coarse_q16();
        return (int'($urandom_range(0, 16)) - 8) * 65536;
    endfunction

    function automatic t_plane gen_plane(int style);
        t_plane p;
        int     axis;
        p = '{a: NORM_W'($urandom), b: NORM_W'($urandom), c: NORM_W'($urandom),
              d: $urandom};
        if (style == ST_FRUSTUM) begin
            p.a = NORM_W'(int'($urandom_range(0, 131072)) - 65536);
            p.b = NORM_W'(int'($urandom_range(0, 131072)) - 65536);
            p.c = NORM_W'(int'($urandom_range(0, 131072)) - 65536);
            p.d = -int'($urandom_range(0, 1 << 24));
        end else if (style == ST_COARSE) begin
            axis = $urandom_range(0, 2);
            p.a  = (axis == 0) ? ($urandom_range(0, 1) ? N_ONE : N_MONE) : '0;
            p.b  = (axis == 1) ? ($urandom_range(0, 1) ? N_ONE : N_MONE) : '0;
            p.c  = (axis == 2) ? ($urandom_range(0, 1) ? N_ONE : N_MONE) : '0;
            p.d  = coarse_q16();
        end
        return p;
    endfunction

    function automatic t_box gen_box(int style);
        int lo[3], hi[3];
        int mid, half, tmp;
        for (int k = 0; k < 3; k++) begin
            lo[k] = $urandom;
            hi[k] = $urandom;
            if (style == ST_FRUSTUM) begin
                mid   = int'($urandom_range(0, 1 << 25)) - (1 << 24);
                half  = $urandom_range(0, 1 << 22);
                lo[k] = mid - half;
                hi[k] = mid + half;
            end else if (style == ST_COARSE) begin
                lo[k] = coarse_q16();
                hi[k] = coarse_q16();
            end
            // mostly ordered corners, now and then swapped ones
            if ((style != ST_FULL) && ((lo[k] > hi[k]) == ($urandom_range(0, 9) != 0))) begin
                tmp   = lo[k];
                lo[k] = hi[k];
                hi[k] = tmp;
            end
        end
        return '{lo_x: lo[0], lo_y: lo[1], lo_z: lo[2], hi_x: hi[0], hi_y: hi[1], hi_z: hi[2]};
    endfunction

    // offer one transaction, hold it until taken, then log its effect
    task automatic issue(t_cull_req r);
        s_valid <= 1'b1;
        s_tdata <= pack_item(r);
        s_tuser <= r.cmd;
        @(posedge i_clk);
        while (!s_axis_tready)
            @(posedge i_clk);
        if (r.cmd == CMD_LOAD) begin
            if (r.idx < NUM_PLANES) begin
                planes_held[r.idx] = r.pl;
                items_done++;
            end
        end else begin
            vis_expected.push_back(r.fixed_en ? r.fixed_vis : box_visible(r.bx));
            items_done++;
        end
        if (!quiet && ($urandom_range(0, 99) < tx_gap_pct)) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge i_clk);
        end
    endtask

    // receiver: random stalls, plus one long hold-off on request
    initial begin
        while (!i_rst_n)
            @(posedge i_clk);
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                hold_req = 1'b0;
                m_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
                m_ready <= 1'b1;
            end else if (!quiet && ($urandom_range(0, 99) < rx_stall_pct)) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 19)) @(posedge i_clk);
                m_ready <= 1'b1;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        bit exp_vis;
        if (i_rst_n && m_axis_tvalid && m_ready) begin
            if (vis_expected.size() == 0) begin
                err_count++;
                $display("%0t: result with none expected, actual %h", $time, m_axis_tdata);
            end else begin
                exp_vis = vis_expected.pop_front();
                if (m_axis_tdata !== M_DATA_W'(exp_vis)) begin
                    err_count++;
                    $display("%0t: visible mismatch, expected %h actual %h",
                             $time, M_DATA_W'(exp_vis), m_axis_tdata);
                end
            end
        end
    end

    initial begin
        t_cull_req rows[$];
        t_cull_req r;
        int        seg, pstyle, bstyle, nload, first, ntest;
        int        pct_choice[3];

        pct_choice = '{0, 10, 40};

        // all planes open: zero normals, most negative offset
        for (int i = 0; i < NUM_PLANES; i++)
            rows.push_back(mk_load(IDX_W'(i), '0, '0, '0, C_MIN));
        rows.push_back(mk_test(C_MIN, C_MIN, C_MIN, C_MAX, C_MAX, C_MAX, 1'b1, 1'b1));
        rows.push_back(mk_test('0, '0, '0, '0, '0, '0, 1'b1, 1'b1));
        // out-of-range indexes must not touch the store
        rows.push_back(mk_load(3'd6, N_MAX, N_MAX, N_MAX, C_MAX));
        rows.push_back(mk_load(3'd7, N_MIN, N_MIN, N_MIN, C_MAX));
        rows.push_back(mk_test(C_MAX, C_MAX, C_MAX, C_MIN, C_MIN, C_MIN, 1'b1, 1'b1));
        // offset alone puts every box outside
        rows.push_back(mk_load(3'd0, '0, '0, '0, C_MAX));
        rows.push_back(mk_test('0, '0, '0, '0, '0, '0, 1'b1, 1'b0));
        // x > 5.0 is outside; a corner on the plane stays visible
        rows.push_back(mk_load(3'd0, N_ONE, '0, '0, 32'shfffb_0000));
        rows.push_back(mk_test(32'sh0005_0000, '0, '0, '0, '0, '0, 1'b1, 1'b1));
        rows.push_back(mk_test(32'sh0005_0001, '0, '0, '0, '0, '0, 1'b1, 1'b0));
        rows.push_back(mk_load(3'd1, N_MIN, N_MAX, N_MIN, '0));
        rows.push_back(mk_test(C_MIN, C_MIN, C_MIN, C_MAX, C_MAX, C_MAX, 1'b0, 1'b0));
        rows.push_back(mk_load(3'd2, N_MAX, N_MIN, N_MAX, C_MIN));
        rows.push_back(mk_test(C_NEG1, C_NEG1, C_NEG1, C_NEG1, C_NEG1, C_NEG1, 1'b0, 1'b0));
        rows.push_back(mk_load(3'd3, N_ULPN, N_ULPN, N_ULPN, C_NEG1));
        rows.push_back(mk_test(32'sh000a_0000, 32'sh000a_0000, 32'sh000a_0000,
                               -32'sh000a_0000, -32'sh000a_0000, -32'sh000a_0000, 1'b0, 1'b0));
        rows.push_back(mk_load(3'd4, '0, N_ONE, N_MONE, '0));
        rows.push_back(mk_test(C_MAX, C_MIN, C_MAX, C_MIN, C_MAX, C_MIN, 1'b0, 1'b0));
        rows.push_back(mk_test('0, '0, '0, '0, '0, '0, 1'b0, 1'b0));

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (rows[i])
            issue(rows[i]);

        seg = 0;
        while (items_done < ITEM_TARGET) begin
            if (items_done >= ITEM_TARGET - QUIET_TAIL)
                quiet = 1'b1;
            tx_gap_pct   = pct_choice[$urandom_range(0, 2)];
            rx_stall_pct = pct_choice[$urandom_range(0, 2)];
            // back-to-back input while the output is held off
            if (seg == 3) begin
                tx_gap_pct = 0;
                hold_req   = 1'b1;
            end

            pstyle = $urandom_range(ST_FULL, ST_COARSE);
            bstyle = ($urandom_range(0, 3) == 0) ? ST_FULL :
                     ((pstyle == ST_COARSE) ? ST_COARSE : ST_FRUSTUM);
            nload  = (seg == 0 || $urandom_range(0, 2) == 0) ? NUM_PLANES :
                     $urandom_range(1, NUM_PLANES - 1);
            first  = $urandom_range(0, NUM_PLANES - 1);
            for (int i = 0; i < nload; i++) begin
                r    = rand_req(CMD_LOAD);
                r.idx = IDX_W'((first + i) % NUM_PLANES);
                r.pl = gen_plane(pstyle);
                issue(r);
            end
            if ($urandom_range(0, 4) == 0) begin
                r     = rand_req(CMD_LOAD);
                r.idx = IDX_W'($urandom_range(NUM_PLANES, 7));
                issue(r);
            end

            ntest = $urandom_range(10, 40);
            for (int i = 0; i < ntest; i++) begin
                if ($urandom_range(0, 19) == 0) begin
                    r     = rand_req(CMD_LOAD);
                    r.idx = IDX_W'($urandom_range(0, NUM_PLANES - 1));
                    r.pl  = gen_plane(pstyle);
                end else begin
                    r    = rand_req(CMD_TEST);
                    r.bx = gen_box(bstyle);
                end
                issue(r);
            end
            seg++;
        end
        s_valid <= 1'b0;

        while (vis_expected.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (err_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
